// ===== rtl/lrrb_pkg.sv =====
// Package for the line receive ring buffer.
// Holds the store depth default, the character codes and the command type
// passed from the front to the back. Depends on nothing.
package lrrb_pkg;

  localparam int unsigned StoreDepthDef = 64;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic KindRx    = 1'b0;
  localparam logic KindDrain = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_LINE,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } bk_state_e;

endpackage

// ===== rtl/lrrb_front.sv =====
// Front part of the line receive ring buffer: classifies input transfers
// and queues the resulting commands for the back part.
// Depends on lrrb_pkg.
module lrrb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          rx_byte_i,
  output lrrb_pkg::cmd_slot_t head_o,
  input  logic                pop_i
);
  import lrrb_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            q_mem [QueueDepth];
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full;
  logic            push;
  cmd_t            new_cmd;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] p);
    return (p == IdxW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    new_cmd.data = rx_byte_i;
    if (kind_i == KindDrain) begin
      new_cmd.op = OP_DRAIN;
    end else if (rx_byte_i == CharLf) begin
      new_cmd.op = OP_LINE;
    end else begin
      new_cmd.op = OP_WRITE;
    end
  end

  assign full       = (count_q == CntW'(QueueDepth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && !((kind_i == KindRx) && (rx_byte_i == CharCr));

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = q_mem[head_q];

  always_comb begin
    head_d  = pop_i ? next_idx(head_q) : head_q;
    tail_d  = push ? next_idx(tail_q) : tail_q;
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[tail_q] <= new_cmd;
    end
  end

endmodule

// ===== rtl/lrrb_back.sv =====
// Back part of the line receive ring buffer: executes queued commands on
// the ring store, the positions and the line flag, and drives the output.
// Depends on lrrb_pkg.
module lrrb_back #(
  parameter int unsigned StoreDepth = lrrb_pkg::StoreDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrrb_pkg::cmd_slot_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o,
  output logic                empty_res_o,
  output logic                line_seen_o
);
  import lrrb_pkg::*;

  localparam int unsigned PtrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic [7:0]      store_mem [StoreDepth];
  logic [PtrW-1:0] write_pos_q, write_pos_d;
  logic [PtrW-1:0] read_pos_q, read_pos_d;
  logic            line_flag_q, line_flag_d;
  logic            drain_flag_q, drain_flag_d;
  bk_state_e       state_q, state_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      rdata_q;
  logic            out_last_q;
  logic            out_empty_q;
  logic            out_line_q;

  logic            out_free;
  logic            issue;
  logic            emit_empty;
  logic            drain_last;
  logic            do_write;
  logic            start_drain;
  logic            store_empty;

  function automatic logic [PtrW-1:0] next_pos(input logic [PtrW-1:0] p);
    return (p == PtrW'(StoreDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign store_empty = (read_pos_q == write_pos_q);
  assign drain_last  = (next_pos(read_pos_q) == write_pos_q);

  always_comb begin
    pop_o = 1'b0;
    if ((state_q == BK_IDLE) && head_i.valid) begin
      pop_o = (head_i.cmd.op != OP_DRAIN) || out_free;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o && (head_i.cmd.op == OP_DRAIN) && !store_empty) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (out_free && drain_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    do_write     = 1'b0;
    start_drain  = 1'b0;
    issue        = 1'b0;
    write_pos_d  = write_pos_q;
    read_pos_d   = read_pos_q;
    line_flag_d  = line_flag_q;
    drain_flag_d = drain_flag_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          case (head_i.cmd.op)
            OP_WRITE: begin
              do_write    = 1'b1;
              write_pos_d = next_pos(write_pos_q);
            end
            OP_LINE: begin
              line_flag_d = 1'b1;
            end
            OP_DRAIN: begin
              start_drain  = 1'b1;
              drain_flag_d = line_flag_q;
              line_flag_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          issue      = 1'b1;
          read_pos_d = next_pos(read_pos_q);
        end
      end
      default: ;
    endcase
  end

  assign emit_empty  = start_drain && store_empty;
  assign out_valid_d = (issue || emit_empty) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      write_pos_q  <= '0;
      read_pos_q   <= '0;
      line_flag_q  <= 1'b0;
      drain_flag_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_pos_q  <= write_pos_d;
      read_pos_q   <= read_pos_d;
      line_flag_q  <= line_flag_d;
      drain_flag_q <= drain_flag_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_mem[write_pos_q] <= head_i.cmd.data;
    end
    if (issue) begin
      rdata_q <= store_mem[read_pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_last_q  <= drain_last;
      out_empty_q <= 1'b0;
      out_line_q  <= drain_flag_q;
    end else if (emit_empty) begin
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
      out_line_q  <= line_flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_empty_q ? 8'h00 : rdata_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;
  assign line_seen_o = out_line_q;

`ifndef SYNTH
  a_no_pop_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRAIN) |-> !pop_o)
    else $error("command taken while a drain is running");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRAIN && out_free && drain_last) |=> (state_q == BK_IDLE))
    else $error("drain did not end after its final byte");

  a_read_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) |=> $stable(read_pos_q))
    else $error("read position moved outside a drain");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty drain result not marked last");
`endif

endmodule

// ===== rtl/line_receive_ring_buffer.sv =====
// Top level of the line receive ring buffer.
// Connects the classifying front and the executing back through the
// command queue. Depends on lrrb_pkg, lrrb_front and lrrb_back.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | kind_i, rx_byte_i
//  out     | out_valid_o/out_stall_i | out_byte_o, last_o, empty_res_o, line_seen_o
//
// Received bytes enter the two-entry command queue while it is not full.
// A drain starts when its command is taken and then reads the stored bytes
// in turn through the single read port of the ring store; an empty drain gives a single empty result.
// Reset clears both positions, the line flag and the queue; the store holds
// no reset value. A stalled output holds its transfer and halts the drain,
// while received bytes keep entering until the queue is full.
module line_receive_ring_buffer #(
  parameter int unsigned StoreDepth = lrrb_pkg::StoreDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       empty_res_o,
  output logic       line_seen_o
);
  import lrrb_pkg::*;

  cmd_slot_t head;
  logic      pop;

  lrrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  lrrb_back #(
    .StoreDepth (StoreDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .line_seen_o (line_seen_o)
  );

endmodule
